>>> design/u8d_pkg.sv
// Package for the UTF-8 stream decoder.
// Holds the decoder state and result types and the Unicode constants.
// No dependencies.
`default_nettype none

package u8d_pkg;

  localparam int unsigned PointW = 21;

  localparam logic [PointW-1:0] MaxPoint    = 21'h10FFFF;
  localparam logic [PointW-1:0] SurrFirst   = 21'h00D800;
  localparam logic [PointW-1:0] SurrLast    = 21'h00DFFF;
  localparam logic [PointW-1:0] LowSurrBase = 21'h00DC00;
  localparam logic [PointW-1:0] Plane1Base  = 21'h010000;
  localparam logic [PointW-1:0] Min2Byte    = 21'h000080;
  localparam logic [PointW-1:0] Min3Byte    = 21'h000800;
  localparam logic [PointW-1:0] BmpLast     = 21'h00FFFF;

  localparam logic [7:0] AsciiLast  = 8'h7F;
  localparam logic [7:0] Lead2First = 8'hC2;
  localparam logic [7:0] Lead2Last  = 8'hDF;
  localparam logic [7:0] Lead3First = 8'hE0;
  localparam logic [7:0] Lead3Last  = 8'hEF;
  localparam logic [7:0] Lead4First = 8'hF0;
  localparam logic [7:0] Lead4Last  = 8'hF4;
  localparam logic [1:0] ContTag    = 2'b10;

  // Lead classes of an open sequence.
  typedef enum logic [1:0] {
    LEAD_NONE  = 2'd0,
    LEAD_TWO   = 2'd1,
    LEAD_THREE = 2'd2,
    LEAD_FOUR  = 2'd3
  } lead_t;

  typedef struct packed {
    logic [PointW-1:0] partial_point;
    logic [1:0]        bytes_due;
    lead_t             lead_class;
    logic              discarding;
  } dec_state_t;

  typedef struct packed {
    logic [PointW-1:0] code_unit;
    logic              is_error;
    logic              text_done;
    logic              last_of_run;
  } result_t;

  // Depth of the result queue; a byte is decoded only when two entries are free.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

endpackage

`default_nettype wire

>>> design/utf8_stream_decoder_top.sv
// UTF-8 to UTF-32/UTF-16 stream decoder, top level.
// Holds the input register, decoder state and result queue. Depends on u8d_pkg, u8d_step.
//
// The decoder takes one UTF-8 byte per cycle as long as the result queue has room for
// two results. A request is captured in an input register; once the queue has room, it
// is decoded against the held state and its zero, one or two results are written into
// a four-entry result queue, which drives the output channel. A byte thus passes the
// input register and the result queue before it reaches the output. A byte giving a
// surrogate pair gives two results, and the output channel bounds the rate to one
// result per cycle while out_tready is high. Errors give one result with
// is_error set, and every following byte is dropped until the end-of-text byte,
// which gives a second error result with text_done set.
`default_nettype none

module utf8_stream_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: bit 0 = utf16_output
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tlast,   // end_of_text
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [20:0] code_unit, [21] text_done, [23:22] zero
  output logic             out_tuser,  // is_error
  output logic             out_tlast   // last_of_run
);
  import u8d_pkg::*;

  logic                utf16_r;
  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  logic                in_eot_r;
  dec_state_t          state_r;
  dec_state_t          state_nxt;
  logic [1:0]          result_cnt;
  result_t             res0;
  result_t             res1;
  result_t             queue_r [QDepth];
  logic [QPtrW-1:0]    wr_ptr_r;
  logic [QPtrW-1:0]    rd_ptr_r;
  logic [QCntW-1:0]    count_r;
  logic                decode_fire;
  logic                pop;
  logic [QCntW-1:0]    push_cnt;
  result_t             head;

  u8d_step u_step (
    .state        (state_r),
    .in_byte      (in_byte_r),
    .end_of_text  (in_eot_r),
    .utf16_output (utf16_r),
    .state_nxt    (state_nxt),
    .result_cnt   (result_cnt),
    .res0         (res0),
    .res1         (res1)
  );

  assign decode_fire = in_valid_r && (count_r <= QCntW'(QDepth - 2));
  assign in_tready   = !in_valid_r || decode_fire;
  assign pop         = out_tvalid && out_tready;
  assign push_cnt    = decode_fire ? QCntW'(result_cnt) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      utf16_r <= 1'b0;
    end else if (cfg_wr_en) begin
      utf16_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (decode_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (decode_fire && result_cnt != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
      if (result_cnt == 2'd2) begin
        queue_r[wr_ptr_r + QPtrW'(1)] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPtrW'(push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      end
      count_r <= count_r + push_cnt - (pop ? QCntW'(1) : '0);
    end
  end

  assign head       = queue_r[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {2'b00, head.text_done, head.code_unit};
  assign out_tuser  = head.is_error;
  assign out_tlast  = head.last_of_run;

endmodule

`default_nettype wire

>>> design/u8d_step.sv
// Decode step of the UTF-8 stream decoder: one byte against the current state.
// Produces up to two results and the next state. Depends on u8d_pkg.
`default_nettype none

module u8d_step (
  input  wire u8d_pkg::dec_state_t state,
  input  wire logic [7:0]          in_byte,
  input  wire logic                end_of_text,
  input  wire logic                utf16_output,
  output u8d_pkg::dec_state_t      state_nxt,
  output logic [1:0]               result_cnt,
  output u8d_pkg::result_t         res0,
  output u8d_pkg::result_t         res1
);
  import u8d_pkg::*;

  logic              err;
  logic              point_ok;
  logic [PointW-1:0] cp;
  logic [PointW-1:0] gathered;
  logic [PointW-1:0] minimum;
  logic [PointW-1:0] offset;
  logic [1:0]        due_dec;
  dec_state_t        open_st;

  assign gathered = {state.partial_point[PointW-7:0], in_byte[5:0]};
  assign due_dec  = state.bytes_due - 2'd1;
  assign offset   = cp - Plane1Base;

  always_comb begin
    unique case (state.lead_class)
      LEAD_TWO:   minimum = Min2Byte;
      LEAD_THREE: minimum = Min3Byte;
      default:    minimum = Plane1Base;
    endcase
  end

  always_comb begin
    err      = 1'b0;
    point_ok = 1'b0;
    cp       = '0;
    open_st  = state;

    if (state.discarding) begin
      err = end_of_text;
    end else if (state.bytes_due == 2'd0) begin
      open_st.discarding = 1'b0;
      if (in_byte <= AsciiLast) begin
        point_ok = 1'b1;
        cp       = {{(PointW-8){1'b0}}, in_byte};
      end else if (in_byte >= Lead2First && in_byte <= Lead2Last) begin
        open_st.partial_point = {{(PointW-5){1'b0}}, in_byte[4:0]};
        open_st.bytes_due     = 2'd1;
        open_st.lead_class    = LEAD_TWO;
        err                   = end_of_text;
      end else if (in_byte >= Lead3First && in_byte <= Lead3Last) begin
        open_st.partial_point = {{(PointW-4){1'b0}}, in_byte[3:0]};
        open_st.bytes_due     = 2'd2;
        open_st.lead_class    = LEAD_THREE;
        err                   = end_of_text;
      end else if (in_byte >= Lead4First && in_byte <= Lead4Last) begin
        open_st.partial_point = {{(PointW-3){1'b0}}, in_byte[2:0]};
        open_st.bytes_due     = 2'd3;
        open_st.lead_class    = LEAD_FOUR;
        err                   = end_of_text;
      end else begin
        err = 1'b1;
      end
    end else if (in_byte[7:6] != ContTag) begin
      err = 1'b1;
    end else if (due_dec != 2'd0) begin
      open_st.partial_point = gathered;
      open_st.bytes_due     = due_dec;
      err                   = end_of_text;
    end else begin
      cp = gathered;
      if (cp < minimum || cp > MaxPoint || (cp >= SurrFirst && cp <= SurrLast)) begin
        err = 1'b1;
      end else begin
        point_ok = 1'b1;
      end
    end
  end

  always_comb begin
    res0       = '0;
    res1       = '0;
    result_cnt = 2'd0;
    state_nxt  = open_st;
    if (err) begin
      res0.is_error    = 1'b1;
      res0.text_done   = end_of_text;
      res0.last_of_run = 1'b1;
      result_cnt       = 2'd1;
      state_nxt        = '0;
      state_nxt.discarding = ~end_of_text;
    end else if (point_ok) begin
      state_nxt = '0;
      if (utf16_output && cp > BmpLast) begin
        res0.code_unit   = SurrFirst + {{(PointW-10){1'b0}}, offset[19:10]};
        res1.code_unit   = LowSurrBase + {{(PointW-10){1'b0}}, offset[9:0]};
        res1.text_done   = end_of_text;
        res1.last_of_run = 1'b1;
        result_cnt       = 2'd2;
      end else begin
        res0.code_unit   = cp;
        res0.text_done   = end_of_text;
        res0.last_of_run = 1'b1;
        result_cnt       = 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the UTF-8 stream decoder, top level utf8_stream_decoder_top.
// It runs directed and random UTF-8 texts in both output modes and checks every result.
// Depends on u8d_pkg and the decoder RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import u8d_pkg::*;

  localparam int ClkHalf    = 6;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int PhaseBytes = 215;

  typedef enum {ROW_PREDICT, ROW_NONE, ROW_UNIT, ROW_ERROR} row_kind_t;

  typedef struct {
    logic [7:0]        b;
    logic              eot;
    row_kind_t         kind;
    logic [PointW-1:0] unit_val;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // Decoder state as predicted by the testbench.
  logic              utf16_mode = 1'b0;
  logic [PointW-1:0] acc_point = '0;
  logic [1:0]        conts_left = 2'd0;
  lead_t             open_lead = LEAD_NONE;
  logic              dropping = 1'b0;

  result_t     expected_units[$];
  result_t     head_unit;
  stim_row_t   stim_rows[$];
  logic [7:0]  text_bytes[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          fed_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_count = 0;
  int          goal;
  int          n_res;
  result_t     res0;
  result_t     res1;

  utf8_stream_decoder_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] in_byte
    .in_tlast   (in_tlast),    // end_of_text
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [20:0] code_unit, [21] text_done, [23:22] zero
    .out_tuser  (out_tuser),   // is_error
    .out_tlast  (out_tlast)    // last_of_run
  );

  always #ClkHalf clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void expect_result(result_t r);
    expected_units.insert(expected_units.size(), r);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  function automatic result_t make_result(logic [PointW-1:0] unit_val, logic err,
                                          logic done, logic last);
    result_t r;
    r.code_unit   = unit_val;
    r.is_error    = err;
    r.text_done   = done;
    r.last_of_run = last;
    return r;
  endfunction

  // Predicts the results of one accepted byte and advances the predicted state.
  function automatic int decode_byte(input logic [7:0] b, input logic eot,
                                     output result_t r0, output result_t r1);
    logic              bad;
    logic              whole;
    logic [PointW-1:0] cp;
    logic [PointW-1:0] floor_pt;
    logic [PointW-1:0] offs;
    int                n;
    bad   = 1'b0;
    whole = 1'b0;
    cp    = '0;
    n     = 0;
    r0    = '0;
    r1    = '0;
    if (dropping) begin
      // After an error only the end of text gives a result again.
      bad = eot;
    end else if (conts_left == 2'd0) begin
      if (b <= AsciiLast) begin
        cp    = {13'd0, b};
        whole = 1'b1;
      end else if (b >= Lead2First && b <= Lead2Last) begin
        acc_point  = {16'd0, b[4:0]};
        conts_left = 2'd1;
        open_lead  = LEAD_TWO;
      end else if (b >= Lead3First && b <= Lead3Last) begin
        acc_point  = {17'd0, b[3:0]};
        conts_left = 2'd2;
        open_lead  = LEAD_THREE;
      end else if (b >= Lead4First && b <= Lead4Last) begin
        acc_point  = {18'd0, b[2:0]};
        conts_left = 2'd3;
        open_lead  = LEAD_FOUR;
      end else begin
        bad = 1'b1;
      end
      // A lead byte at the end of the text leaves its sequence truncated.
      if (!whole && eot) bad = 1'b1;
    end else if (b[7:6] != ContTag) begin
      bad = 1'b1;
    end else begin
      acc_point  = {acc_point[14:0], b[5:0]};
      conts_left = conts_left - 2'd1;
      if (conts_left != 2'd0) begin
        bad = eot;
      end else begin
        cp = acc_point;
        case (open_lead)
          LEAD_TWO:   floor_pt = Min2Byte;
          LEAD_THREE: floor_pt = Min3Byte;
          default:    floor_pt = Plane1Base;
        endcase
        if (cp < floor_pt || cp > MaxPoint || (cp >= SurrFirst && cp <= SurrLast))
          bad = 1'b1;
        else
          whole = 1'b1;
      end
    end

    if (bad) begin
      r0       = make_result('0, 1'b1, eot, 1'b1);
      n        = 1;
      dropping = !eot;
    end else if (whole) begin
      if (utf16_mode && cp > BmpLast) begin
        offs = cp - Plane1Base;
        r0   = make_result(SurrFirst + {11'd0, offs[19:10]}, 1'b0, 1'b0, 1'b0);
        r1   = make_result(LowSurrBase + {11'd0, offs[9:0]}, 1'b0, eot, 1'b1);
        n    = 2;
      end else begin
        r0 = make_result(cp, 1'b0, eot, 1'b1);
        n  = 1;
      end
    end
    if (bad || whole) begin
      acc_point  = '0;
      conts_left = 2'd0;
      open_lead  = LEAD_NONE;
    end
    return n;
  endfunction

  function automatic void add_row(logic [7:0] b, logic eot, row_kind_t kind,
                                  logic [PointW-1:0] unit_val = '0);
    stim_row_t row;
    row.b        = b;
    row.eot      = eot;
    row.kind     = kind;
    row.unit_val = unit_val;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // Appends the UTF-8 form of a point in the given number of bytes, overlong or not.
  function automatic void put_point(logic [PointW-1:0] cp, int len);
    case (len)
      1: add_byte(cp[7:0]);
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({ContTag, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({ContTag, cp[11:6]});
        add_byte({ContTag, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({ContTag, cp[17:12]});
        add_byte({ContTag, cp[11:6]});
        add_byte({ContTag, cp[5:0]});
      end
    endcase
  endfunction

  // Mostly well-formed characters; now and then one of the malformed forms.
  function automatic void build_text();
    int                chars;
    int                pick;
    int                len;
    int                pos;
    logic [PointW-1:0] cp;
    logic [7:0]        b;
    bit                cut;
    text_bytes.delete();
    chars = $urandom_range(1, 8);
    cut   = 1'b0;
    for (int c = 0; c < chars && !cut; c++) begin
      pick = $urandom_range(0, 99);
      if (pick < 92) begin
        if (pick < 25) begin
          len = 1;
          cp  = PointW'($urandom_range(0, 'h7F));
        end else if (pick < 45) begin
          len = 2;
          cp  = PointW'($urandom_range('h80, 'h7FF));
        end else if (pick < 68) begin
          len = 3;
          cp  = PointW'($urandom_range('h800, 'hFFFF));
          if (cp >= SurrFirst && cp <= SurrLast) cp = cp - PointW'('h1000);
        end else begin
          len = 4;
          cp  = PointW'($urandom_range('h10000, 'h10FFFF));
        end
        put_point(cp, len);
      end else begin
        case ($urandom_range(0, 6))
          0: begin
            if ($urandom_range(0, 1) == 0)
              add_byte(8'($urandom_range('h80, 'hC1)));
            else
              add_byte(8'($urandom_range('hF5, 'hFF)));
          end
          1: begin
            if ($urandom_range(0, 1) == 0)
              put_point(PointW'($urandom_range(0, 'h7FF)), 3);
            else
              put_point(PointW'($urandom_range(0, 'hFFFF)), 4);
          end
          2: put_point(PointW'($urandom_range('hD800, 'hDFFF)), 3);
          3: put_point(PointW'($urandom_range('h110000, 'h13FFFF)), 4);
          4: begin
            len = $urandom_range(2, 4);
            pos = text_bytes.size() + $urandom_range(1, len - 1);
            put_point(PointW'($urandom_range('h80, 'h10FFFF)), len);
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == ContTag) b[6] = 1'b1;
            text_bytes[pos] = b;
          end
          5: begin
            len = $urandom_range(2, 4);
            put_point(PointW'($urandom_range('h80, 'h10FFFF)), len);
            repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
            cut = 1'b1;
          end
          default: add_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eot, output int n,
                           output result_t r0, output result_t r1);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!dropping) fed_count++;
    n = decode_byte(b, eot, r0, r1);
  endtask

  task automatic send_text();
    int      n;
    result_t r0;
    result_t r1;
    build_text();
    foreach (text_bytes[i]) begin
      send_byte(text_bytes[i], i == text_bytes.size() - 1, n, r0, r1);
      if (n > 0) expect_result(r0);
      if (n > 1) expect_result(r1);
    end
  endtask

  // Waits until every expected result is out, plus a margin for bytes in flight
  // that give no result.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    utf16_mode = mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: random stalls, or a long hold-off while pressure is requested.
  always @(negedge clk) begin
    if (hold_req && hold_count < HoldCycles) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      if (!hold_req) hold_count <= 0;
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_units.size() == 0) begin
        $error("unexpected result: code_unit %h is_error %b", out_tdata[20:0], out_tuser);
        mismatch_count++;
      end else begin
        head_unit = expected_units.pop_front();
        if (out_tdata[20:0] !== head_unit.code_unit) begin
          $error("code_unit: expected %h, got %h", head_unit.code_unit, out_tdata[20:0]);
          mismatch_count++;
        end
        if (out_tuser !== head_unit.is_error) begin
          $error("is_error: expected %b, got %b", head_unit.is_error, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[21] !== head_unit.text_done) begin
          $error("text_done: expected %b, got %b", head_unit.text_done, out_tdata[21]);
          mismatch_count++;
        end
        if (out_tlast !== head_unit.last_of_run) begin
          $error("last_of_run: expected %b, got %b", head_unit.last_of_run, out_tlast);
          mismatch_count++;
        end
        if (out_tdata[23:22] !== 2'b00) begin
          $error("tdata padding: expected 00, got %b", out_tdata[23:22]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    // Plain text, a two-byte point and the largest three-byte point.
    add_row(8'h00, 1'b0, ROW_UNIT, 21'h000000);
    add_row(8'hC2, 1'b0, ROW_NONE);
    add_row(8'h80, 1'b0, ROW_UNIT, 21'h000080);
    add_row(8'hEF, 1'b0, ROW_PREDICT);
    add_row(8'hBF, 1'b0, ROW_PREDICT);
    add_row(8'hBF, 1'b1, ROW_PREDICT);
    // Above the last code point, then dropped bytes up to the end of text.
    add_row(8'hF4, 1'b0, ROW_NONE);
    add_row(8'h90, 1'b0, ROW_NONE);
    add_row(8'h80, 1'b0, ROW_NONE);
    add_row(8'h80, 1'b0, ROW_ERROR);
    add_row(8'h7F, 1'b1, ROW_ERROR);
    // A surrogate whose last byte also ends the text.
    add_row(8'hED, 1'b0, ROW_NONE);
    add_row(8'hA0, 1'b0, ROW_NONE);
    add_row(8'h80, 1'b1, ROW_ERROR);
    // Bad lead bytes: the one just below the two-byte leads and the last byte value.
    add_row(8'hC1, 1'b0, ROW_ERROR);
    add_row(8'hFF, 1'b1, ROW_ERROR);
    // Overlong three-byte form.
    add_row(8'hE0, 1'b0, ROW_NONE);
    add_row(8'h9F, 1'b0, ROW_NONE);
    add_row(8'hBF, 1'b0, ROW_ERROR);
    add_row(8'hF5, 1'b1, ROW_ERROR);
    // Missing continuation byte.
    add_row(8'hC2, 1'b0, ROW_NONE);
    add_row(8'h41, 1'b0, ROW_ERROR);
    add_row(8'h80, 1'b1, ROW_ERROR);
    // Truncated by the end of text.
    add_row(8'hF0, 1'b1, ROW_ERROR);
    add_row(8'hDF, 1'b0, ROW_PREDICT);
    add_row(8'hBF, 1'b1, ROW_PREDICT);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      send_byte(stim_rows[i].b, stim_rows[i].eot, n_res, res0, res1);
      case (stim_rows[i].kind)
        ROW_PREDICT: begin
          if (n_res > 0) expect_result(res0);
          if (n_res > 1) expect_result(res1);
        end
        ROW_UNIT:
          expect_result(make_result(stim_rows[i].unit_val, 1'b0,
                                    stim_rows[i].eot, 1'b1));
        ROW_ERROR:
          expect_result(make_result('0, 1'b1, stim_rows[i].eot, 1'b1));
        default: ;
      endcase
    end

    for (int p = 0; p < 8; p++) begin
      settle();
      write_mode(p[0]);
      case (p / 2)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      goal = fed_count + PhaseBytes;
      while (fed_count < goal) send_text();
    end

    // Hold the receiver off long enough for the decoder to stall its input.
    settle();
    write_mode(1'b1);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    goal = fed_count + 60;
    while (fed_count < goal) send_text();
    settle();
    hold_req = 1'b0;

    if (mismatch_count == 0 && expected_units.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
design/u8d_pkg.sv
design/u8d_step.sv
design/utf8_stream_decoder_top.sv
dv/tb_top.sv
